[rtl/core/chd_pkg.sv]
// Shared types and constants for the chunked body decoder.
package chd_pkg;

  localparam int SIZE_BITS_DEFAULT   = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // One classified input word as it travels from front to back.
  typedef struct packed {
    logic       kind;      // end of stream / read failure
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_space;  // SP, TAB, LF, VT, FF, CR
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
  } item_t;

endpackage

[rtl/core/http_chunked_body_decoder_core.sv]
// Top level of the HTTP/1.1 chunked body decoder.
//
// Input stream (s_*): one word per received byte. s_tdata carries the byte,
// s_tuser marks end of stream or a read failure (data ignored then).
// Output stream (m_*): exactly one word per input word, in order. m_tdata is
// the decoded body byte (zero when none), m_tuser carries the flags
// body_valid, message_done and framing_error from bit 0 up.
// Size lines, chunk CR LF and trailers produce words with all flags low.
//
// Throughput: one word per cycle in both directions while the receiver keeps
// up. An accepted word is written into the front queue, then passes through the
// back end state machine into its output register before it shows on m_*.
// The front classifies bytes into a QUEUE_DEPTH-word queue; the back end
// pops one word a cycle while its output register is free or being taken.
// When the receiver stalls, the queue absorbs up to QUEUE_DEPTH words, then
// s_tready drops until the output drains.
// Reset (rst, synchronous): queue emptied, output cleared, decoder returned
// to the start of a chunk-size line. An end-of-stream word restarts it too,
// but one that arrives before the message is done is flagged and leaves the
// decoder halted until the next end of stream.
module http_chunked_body_decoder_core #(
  parameter int SIZE_BITS   = chd_pkg::SIZE_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = chd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] body_byte
  output logic [2:0] m_tuser    // [0] body_valid, [1] message_done, [2] framing_error
);

  chd_pkg::item_t push_item;
  chd_pkg::item_t head;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_valid;

  chd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  chd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  chd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .it       (head),
    .it_valid (q_valid),
    .it_pop   (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // at most one flag per output word
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tuser) <= 1))
    else $error("output flags not exclusive");

  // non-body words carry a zero byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
    else $error("nonzero byte on a non-body word");

  // nothing presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

[rtl/core/chd_front.sv]
// Front end: input handshake and byte classification.
module chd_front (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tuser,
  input  logic             q_full,
  output logic             q_push,
  output chd_pkg::item_t   q_item
);

  logic is_digit;
  logic is_lower;
  logic is_upper;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
    is_lower = (s_tdata >= 8'h61) && (s_tdata <= 8'h66);
    is_upper = (s_tdata >= 8'h41) && (s_tdata <= 8'h46);

    q_item.kind     = s_tuser;
    q_item.data     = s_tdata;
    q_item.is_hex   = is_digit || is_lower || is_upper;
    // letters: low nibble 1..6 maps to 10..15
    q_item.hex_val  = is_digit ? s_tdata[3:0] : s_tdata[3:0] + 4'd9;
    q_item.is_space = (s_tdata == chd_pkg::CH_SPACE) ||
                      ((s_tdata >= chd_pkg::CH_TAB) && (s_tdata <= chd_pkg::CH_CR));
    q_item.is_cr    = (s_tdata == chd_pkg::CH_CR);
    q_item.is_lf    = (s_tdata == chd_pkg::CH_LF);
    q_item.is_semi  = (s_tdata == chd_pkg::CH_SEMI);
  end

endmodule

[rtl/core/chd_queue.sv]
// Small FIFO of classified words between front and back.
module chd_queue #(
  parameter int DEPTH = chd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  chd_pkg::item_t push_item,
  input  logic           pop,
  output chd_pkg::item_t head,
  output logic           full,
  output logic           not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

  chd_pkg::item_t     slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == FULLC);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/core/chd_back.sv]
// Back end: framing state machine, size counter and output register.
module chd_back #(
  parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  chd_pkg::item_t it,
  input  logic           it_valid,
  output logic           it_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic [2:0]     m_tuser
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_DIGITS, PH_TAIL, PH_EXT, PH_DATA, PH_SKIP, PH_TRAILER, PH_HALT
  } phase_t;

  phase_t                 phase, phase_next, ph;
  logic [SIZE_BITS-1:0]   size_count, size_next;
  logic                   digit_seen, digit_next;
  logic                   cr_pending, cr_next;
  logic                   line_nonempty, line_next;
  logic [1:0]             skip_left, skip_next;
  logic                   r_valid, r_done, r_err;
  logic [7:0]             r_byte;
  logic                   top_nz;

  assign it_pop = it_valid && (!m_tvalid || m_tready);
  assign top_nz = (size_count[SIZE_BITS-1 -: 4] != 4'd0);

  always_comb begin
    phase_next = phase;
    size_next  = size_count;
    digit_next = digit_seen;
    cr_next    = cr_pending;
    line_next  = line_nonempty;
    skip_next  = skip_left;
    r_valid    = 1'b0;
    r_byte     = 8'd0;
    r_done     = 1'b0;
    r_err      = 1'b0;
    ph         = phase;

    if (it.kind) begin
      r_err      = (phase != PH_HALT);
      phase_next = PH_LEAD;
      size_next  = '0;
      digit_next = 1'b0;
      cr_next    = 1'b0;
      line_next  = 1'b0;
      skip_next  = 2'd0;
    end else begin
      unique case (phase)
        PH_LEAD, PH_DIGITS, PH_TAIL, PH_EXT: begin
          if (cr_pending && it.is_lf) begin
            cr_next = 1'b0;
            if (!digit_seen) begin
              r_err = 1'b1;
            end else if (size_count == '0) begin
              phase_next = PH_TRAILER;
              line_next  = 1'b0;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            // a held CR that was not a line end counts as whitespace
            if (cr_pending) begin
              cr_next = 1'b0;
              if (ph == PH_DIGITS) ph = PH_TAIL;
            end
            phase_next = ph;
            if (it.is_cr) begin
              cr_next = 1'b1;
            end else if (ph == PH_EXT) begin
              phase_next = PH_EXT;
            end else if (it.is_semi) begin
              if (!digit_seen) r_err = 1'b1;
              else phase_next = PH_EXT;
            end else if (it.is_space) begin
              if (ph == PH_DIGITS) phase_next = PH_TAIL;
            end else if (!it.is_hex || ph == PH_TAIL || top_nz) begin
              r_err = 1'b1;
            end else begin
              size_next  = {size_count[SIZE_BITS-5:0], it.hex_val};
              digit_next = 1'b1;
              phase_next = PH_DIGITS;
            end
          end
        end
        PH_DATA: begin
          r_valid   = 1'b1;
          r_byte    = it.data;
          size_next = size_count - 1'b1;
          if (size_count == SIZE_BITS'(1)) begin
            phase_next = PH_SKIP;
            skip_next  = 2'd2;
          end
        end
        PH_SKIP: begin
          skip_next = skip_left - 2'd1;
          if (skip_left == 2'd1) begin
            phase_next = PH_LEAD;
            size_next  = '0;
            digit_next = 1'b0;
            cr_next    = 1'b0;
          end
        end
        PH_TRAILER: begin
          if (cr_pending && it.is_lf) begin
            cr_next   = 1'b0;
            line_next = 1'b0;
            if (!line_nonempty) begin
              r_done     = 1'b1;
              phase_next = PH_HALT;
            end
          end else if (it.is_cr) begin
            if (cr_pending) line_next = 1'b1;
            cr_next = 1'b1;
          end else begin
            line_next = 1'b1;
            cr_next   = 1'b0;
          end
        end
        PH_HALT: begin
          phase_next = PH_HALT;
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end

    if (r_err) phase_next = PH_HALT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      size_count    <= '0;
      digit_seen    <= 1'b0;
      cr_pending    <= 1'b0;
      line_nonempty <= 1'b0;
      skip_left     <= 2'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (it_pop) begin
        phase         <= phase_next;
        size_count    <= size_next;
        digit_seen    <= digit_next;
        cr_pending    <= cr_next;
        line_nonempty <= line_next;
        skip_left     <= skip_next;
        m_tvalid      <= 1'b1;
        m_tdata       <= r_byte;
        m_tuser       <= {r_err, r_done, r_valid};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
